@@ sv/led_chain_shadow_image_engine_macros.svh @@
// Assertion macros for the LED chain shadow image engine checker.
// Expects i_clk and i_rst_n in the scope of use; included by the checker file only.
`ifndef LED_CHAIN_SHADOW_IMAGE_ENGINE_MACROS_SVH
`define LED_CHAIN_SHADOW_IMAGE_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define LCSIE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lcsie: same-cycle check failed");

// Next-cycle implication, disabled while reset is held
`define LCSIE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lcsie: next-cycle check failed");

`endif

@@ sv/lcsie_pkg.sv @@
// Shared types and constants for the LED chain shadow image engine.
// No dependencies; imported by the byte unit and the top level.
package lcsie_pkg;

    localparam int MAX_REGISTERS = 8;
    localparam int FRAME_LIMIT   = 8;
    localparam int IDX_W         = $clog2(MAX_REGISTERS);
    localparam int LEN_W         = 4;
    localparam int OP_W          = 5;
    localparam int POS_W         = 6;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 4;

    // Lengths in use are capped by the image depth and the frame limit
    localparam int USED_MAX = (MAX_REGISTERS < FRAME_LIMIT) ? MAX_REGISTERS : FRAME_LIMIT;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLR_REG            = 5'd0;
    localparam logic [OP_W-1:0] OP_CLR_ALL            = 5'd1;
    localparam logic [OP_W-1:0] OP_FILL_REG           = 5'd2;
    localparam logic [OP_W-1:0] OP_FILL_ALL           = 5'd3;
    localparam logic [OP_W-1:0] OP_SET_REG            = 5'd4;
    localparam logic [OP_W-1:0] OP_SET_REG_ONLY       = 5'd5;
    localparam logic [OP_W-1:0] OP_SET_CHAIN          = 5'd6;
    localparam logic [OP_W-1:0] OP_SET_CHAIN_ONLY     = 5'd7;
    localparam logic [OP_W-1:0] OP_SET_EACH           = 5'd8;
    localparam logic [OP_W-1:0] OP_SET_EACH_ONLY      = 5'd9;
    localparam logic [OP_W-1:0] OP_CLRB_REG           = 5'd10;
    localparam logic [OP_W-1:0] OP_CLRB_REG_ONLY      = 5'd11;
    localparam logic [OP_W-1:0] OP_CLRB_CHAIN         = 5'd12;
    localparam logic [OP_W-1:0] OP_CLRB_CHAIN_ONLY    = 5'd13;
    localparam logic [OP_W-1:0] OP_CLRB_EACH          = 5'd14;
    localparam logic [OP_W-1:0] OP_CLRB_EACH_ONLY     = 5'd15;
    localparam logic [OP_W-1:0] OP_SHL_REG            = 5'd16;
    localparam logic [OP_W-1:0] OP_SHL_CHAIN          = 5'd17;
    localparam logic [OP_W-1:0] OP_SHL_EACH           = 5'd18;
    localparam logic [OP_W-1:0] OP_SHR_REG            = 5'd19;
    localparam logic [OP_W-1:0] OP_SHR_CHAIN          = 5'd20;
    localparam logic [OP_W-1:0] OP_SHR_EACH           = 5'd21;
    localparam logic [OP_W-1:0] OP_INV_REG            = 5'd22;
    localparam logic [OP_W-1:0] OP_INV_ALL            = 5'd23;
    localparam logic [OP_W-1:0] OP_UPDATE             = 5'd24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHAIN_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ON_EDIT = 2'd1;

    localparam logic [LEN_W-1:0] CHAIN_LENGTH_RST  = 4'd8;
    localparam logic             FRAME_ON_EDIT_RST = 1'b1;

    // Control handed to the shared byte unit on every sweep step
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            hit_reg;
        logic            hit_chain;
        logic [7:0]      mask;
        logic            circ;
        logic            carry_in;
    } t_unit_ctrl;

endpackage

@@ sv/lcsie_byte_unit.sv @@
// Shared byte unit: applies one image operation to one byte per cycle.
// Depends on lcsie_pkg.
module lcsie_byte_unit
    import lcsie_pkg::*;
(
    input  t_unit_ctrl i_ctrl,
    input  logic [7:0] i_byte,
    output logic [7:0] o_byte,
    output logic       o_carry
);

    logic [7:0] rot_l;
    logic [7:0] rot_r;

    // Rotate or shift by one within the byte
    assign rot_l = {i_byte[6:0], i_ctrl.circ & i_byte[7]};
    assign rot_r = {i_ctrl.circ & i_byte[0], i_byte[7:1]};

    always_comb begin
        o_byte  = i_byte;
        o_carry = 1'b0;
        case (i_ctrl.op)
            OP_CLR_REG:         if (i_ctrl.hit_reg) o_byte = 8'h00;
            OP_CLR_ALL:         o_byte = 8'h00;
            OP_FILL_REG:        if (i_ctrl.hit_reg) o_byte = 8'hFF;
            OP_FILL_ALL:        o_byte = 8'hFF;
            OP_SET_REG:         if (i_ctrl.hit_reg) o_byte = i_byte | i_ctrl.mask;
            OP_SET_REG_ONLY:    if (i_ctrl.hit_reg) o_byte = i_ctrl.mask;
            OP_SET_CHAIN:       if (i_ctrl.hit_chain) o_byte = i_byte | i_ctrl.mask;
            OP_SET_CHAIN_ONLY:  o_byte = i_ctrl.hit_chain ? i_ctrl.mask : 8'h00;
            OP_SET_EACH:        o_byte = i_byte | i_ctrl.mask;
            OP_SET_EACH_ONLY:   o_byte = i_ctrl.mask;
            OP_CLRB_REG:        if (i_ctrl.hit_reg) o_byte = i_byte & ~i_ctrl.mask;
            OP_CLRB_REG_ONLY:   if (i_ctrl.hit_reg) o_byte = ~i_ctrl.mask;
            OP_CLRB_CHAIN:      if (i_ctrl.hit_chain) o_byte = i_byte & ~i_ctrl.mask;
            OP_CLRB_CHAIN_ONLY: o_byte = i_ctrl.hit_chain ? ~i_ctrl.mask : 8'hFF;
            OP_CLRB_EACH:       o_byte = i_byte & ~i_ctrl.mask;
            OP_CLRB_EACH_ONLY:  o_byte = ~i_ctrl.mask;
            OP_SHL_REG:         if (i_ctrl.hit_reg) o_byte = rot_l;
            OP_SHL_CHAIN: begin
                o_byte  = {i_byte[6:0], i_ctrl.carry_in};
                o_carry = i_byte[7];
            end
            OP_SHL_EACH:        o_byte = rot_l;
            OP_SHR_REG:         if (i_ctrl.hit_reg) o_byte = rot_r;
            OP_SHR_CHAIN: begin
                o_byte  = {i_ctrl.carry_in, i_byte[7:1]};
                o_carry = i_byte[0];
            end
            OP_SHR_EACH:        o_byte = rot_r;
            OP_INV_REG:         if (i_ctrl.hit_reg) o_byte = ~i_byte;
            OP_INV_ALL:         o_byte = ~i_byte;
            default:            o_byte = i_byte;
        endcase
    end

endmodule

@@ sv/led_chain_shadow_image_engine.sv @@
// Top level of the LED chain shadow image engine; uses lcsie_pkg and lcsie_byte_unit.
// Sequence: after accept, ST_PREP for chain shifts, then a sweep over the L bytes in use (none
// for update or a rejected op), then any frame beats back to back; L = chain length in use.
// A new op is accepted only when idle, once the previous one is done; sweep and frame are serialised
// by the single image read port and the shared byte unit, one byte per cycle.
// Reset (synchronous, active low): image zero, length 8, frame-on-edit 1; no receiver stall.
module led_chain_shadow_image_engine
    import lcsie_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [OP_W-1:0]       i_op,
    input  logic [IDX_W-1:0]      i_reg_index,
    input  logic [POS_W-1:0]      i_bit_position,
    input  logic                  i_circular,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_strobe,
    output logic                  o_frame_valid,
    output logic [7:0]            o_frame_byte,
    output logic                  o_last,
    output logic                  o_ok
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_SWEEP,
        ST_EMIT
    } t_state;

    t_state               r_state;
    logic [LEN_W-1:0]     r_chain_length;
    logic                 r_frame_on_edit;
    logic [7:0]           r_image [MAX_REGISTERS];
    logic [OP_W-1:0]      r_op;
    logic [IDX_W-1:0]     r_ri;
    logic [POS_W-1:0]     r_pos;
    logic                 r_circ;
    logic                 r_ok;
    logic                 r_emit;
    logic [IDX_W-1:0]     r_top;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_carry;
    logic                 r_strobe;
    logic                 r_frame_valid;
    logic [7:0]           r_frame_byte;
    logic                 r_last;
    logic                 r_ok_out;

    logic [IDX_W-1:0]     used_top;
    logic [LEN_W-1:0]     used_len;
    logic                 accept;
    logic                 reg_ok;
    logic                 bit_ok;
    logic                 chain_ok;
    logic                 dec_ok;
    logic                 dec_emit;
    logic                 dec_sweep;
    logic                 dec_chain;
    logic [7:0]           rd_byte;
    t_unit_ctrl           unit_ctrl;
    logic [7:0]           unit_byte;
    logic                 unit_carry;
    logic                 sweep_down;
    logic                 sweep_end;

    assign accept      = start && (r_state == ST_IDLE);
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // Length in use: 0 acts as 1, anything above the cap acts as the cap
    always_comb begin
        if (r_chain_length == '0) begin
            used_top = '0;
        end else if (r_chain_length > LEN_W'(USED_MAX)) begin
            used_top = IDX_W'(USED_MAX - 1);
        end else begin
            used_top = IDX_W'(r_chain_length - LEN_W'(1));
        end
    end
    assign used_len = LEN_W'(used_top) + LEN_W'(1);

    // Index checks
    assign reg_ok   = LEN_W'(i_reg_index) < used_len;
    assign bit_ok   = (i_bit_position[POS_W-1:3] == '0);
    assign chain_ok = LEN_W'(i_bit_position[POS_W-1:3]) < used_len;

    // Operation decode at accept
    always_comb begin
        dec_ok    = 1'b0;
        dec_emit  = r_frame_on_edit;
        dec_chain = 1'b0;
        case (i_op)
            OP_CLR_REG, OP_FILL_REG, OP_SHL_REG, OP_SHR_REG, OP_INV_REG:
                dec_ok = reg_ok;
            OP_CLR_ALL, OP_FILL_ALL, OP_SHL_EACH, OP_SHR_EACH, OP_INV_ALL:
                dec_ok = 1'b1;
            OP_SHL_CHAIN, OP_SHR_CHAIN: begin
                dec_ok    = 1'b1;
                dec_chain = 1'b1;
            end
            OP_SET_REG, OP_SET_REG_ONLY, OP_CLRB_REG, OP_CLRB_REG_ONLY:
                dec_ok = reg_ok && bit_ok;
            OP_SET_CHAIN, OP_SET_CHAIN_ONLY, OP_CLRB_CHAIN, OP_CLRB_CHAIN_ONLY:
                dec_ok = chain_ok;
            OP_SET_EACH, OP_SET_EACH_ONLY, OP_CLRB_EACH, OP_CLRB_EACH_ONLY:
                dec_ok = bit_ok;
            OP_UPDATE: begin
                dec_ok   = 1'b1;
                dec_emit = 1'b1;
            end
            default: begin
                dec_ok   = 1'b0;
                dec_emit = 1'b0;
            end
        endcase
    end
    assign dec_sweep = dec_ok && (i_op != OP_UPDATE);

    // Single image read port, addressed by the sequencer index
    assign rd_byte = r_image[r_idx];

    assign unit_ctrl.op        = r_op;
    assign unit_ctrl.hit_reg   = (r_idx == r_ri);
    assign unit_ctrl.hit_chain = (r_idx == r_pos[POS_W-1:3]);
    assign unit_ctrl.mask      = 8'h01 << r_pos[2:0];
    assign unit_ctrl.circ      = r_circ;
    assign unit_ctrl.carry_in  = r_carry;

    lcsie_byte_unit u_unit (
        .i_ctrl  (unit_ctrl),
        .i_byte  (rd_byte),
        .o_byte  (unit_byte),
        .o_carry (unit_carry)
    );

    // Chain right shift walks from the top byte down, all else upwards
    assign sweep_down = (r_op == OP_SHR_CHAIN);
    assign sweep_end  = sweep_down ? (r_idx == '0) : (r_idx == r_top);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain_length  <= CHAIN_LENGTH_RST;
            r_frame_on_edit <= FRAME_ON_EDIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CHAIN_LENGTH:  r_chain_length  <= i_cfg_data;
                CFG_FRAME_ON_EDIT: r_frame_on_edit <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer, image and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
            r_idx    <= '0;
            for (int i = 0; i < MAX_REGISTERS; i++) begin
                r_image[i] <= 8'h00;
            end
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_op   <= i_op;
                        r_ri   <= i_reg_index;
                        r_pos  <= i_bit_position;
                        r_circ <= i_circular;
                        r_ok   <= dec_ok;
                        r_emit <= dec_emit;
                        r_top  <= used_top;
                        if (dec_sweep && dec_chain) begin
                            // read the byte whose end bit wraps round
                            r_idx   <= (i_op == OP_SHL_CHAIN) ? used_top : '0;
                            r_state <= ST_PREP;
                        end else if (dec_sweep) begin
                            r_idx   <= '0;
                            r_state <= ST_SWEEP;
                        end else if (dec_emit) begin
                            r_idx   <= used_top;
                            r_state <= ST_EMIT;
                        end else begin
                            r_strobe      <= 1'b1;
                            r_frame_valid <= 1'b0;
                            r_frame_byte  <= 8'h00;
                            r_last        <= 1'b1;
                            r_ok_out      <= dec_ok;
                        end
                    end
                end
                ST_PREP: begin
                    if (r_op == OP_SHL_CHAIN) begin
                        r_carry <= r_circ & rd_byte[7];
                        r_idx   <= '0;
                    end else begin
                        r_carry <= r_circ & rd_byte[0];
                        r_idx   <= r_top;
                    end
                    r_state <= ST_SWEEP;
                end
                ST_SWEEP: begin
                    r_image[r_idx] <= unit_byte;
                    r_carry        <= unit_carry;
                    if (sweep_end) begin
                        if (r_emit) begin
                            r_idx   <= r_top;
                            r_state <= ST_EMIT;
                        end else begin
                            r_strobe      <= 1'b1;
                            r_frame_valid <= 1'b0;
                            r_frame_byte  <= 8'h00;
                            r_last        <= 1'b1;
                            r_ok_out      <= r_ok;
                            r_state       <= ST_IDLE;
                        end
                    end else if (sweep_down) begin
                        r_idx <= r_idx - IDX_W'(1);
                    end else begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                ST_EMIT: begin
                    // highest byte first, one beat per cycle
                    r_strobe      <= 1'b1;
                    r_frame_valid <= 1'b1;
                    r_frame_byte  <= rd_byte;
                    r_last        <= (r_idx == '0);
                    r_ok_out      <= r_ok;
                    if (r_idx == '0) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_idx <= r_idx - IDX_W'(1);
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_strobe      = r_strobe;
    assign o_frame_valid = r_frame_valid;
    assign o_frame_byte  = r_frame_byte;
    assign o_last        = r_last;
    assign o_ok          = r_ok_out;

endmodule

@@ sv/lcsie_checker.sv @@
// Port-level checks on the result stream of the LED chain shadow image engine.
// Depends on led_chain_shadow_image_engine_macros.svh; bound to the top level.
`include "led_chain_shadow_image_engine_macros.svh"

module lcsie_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       busy,
    input logic       o_strobe,
    input logic       o_frame_valid,
    input logic [7:0] o_frame_byte,
    input logic       o_last,
    input logic       o_ok
);

    // A beat without frame data is a lone, final beat carrying zero
    `LCSIE_ASSERT_NOW(a_noframe_last, o_strobe && !o_frame_valid, o_last && o_frame_byte == 8'h00)

    // Frame beats come back to back until the last one
    `LCSIE_ASSERT_NEXT(a_frame_contig, o_strobe && !o_last, o_strobe && o_frame_valid)

    // ok holds the same value across one frame
    `LCSIE_ASSERT_NEXT(a_ok_steady, o_strobe && !o_last, o_ok == $past(o_ok))

    // A frame in flight means the block is still busy
    `LCSIE_ASSERT_NOW(a_busy_in_frame, o_strobe && !o_last, busy)

endmodule

bind led_chain_shadow_image_engine lcsie_checker u_lcsie_checker (.*);
